// ----- hdl/pxb_pkg.sv -----
// ----------------------------------------------------------------------------
// pxb_pkg
// Shared types and constants for the prefix XOR basis block.
// ----------------------------------------------------------------------------
package pxb_pkg;

    localparam int VALUE_BITS    = 23;
    localparam int POSITION_BITS = 20;
    localparam int LEVEL_BITS    = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0]    value_t;
    typedef logic [POSITION_BITS-1:0] position_t;
    typedef logic [LEVEL_BITS-1:0]    level_t;

    localparam level_t TOP_LEVEL = level_t'(VALUE_BITS - 1);
    localparam level_t BOTTOM_LEVEL = level_t'(0);

    // Request codes
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } req_type_t;

    // One basis slot as stored in memory
    typedef struct packed {
        position_t pos;
        value_t    vec;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // Result of processing one level
    typedef struct packed {
        logic      wr_en;
        entry_t    wr_entry;
        value_t    val_next;
        position_t pos_next;
        value_t    acc_next;
    } step_out_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

endpackage

// ----- hdl/pxb_ram.sv -----
// ----------------------------------------------------------------------------
// pxb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pxb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/pxb_step.sv -----
// ----------------------------------------------------------------------------
// pxb_step
// One bit level of work: insert reduction with slot displacement, or one
// greedy step of the maximum-XOR query.
// ----------------------------------------------------------------------------
module pxb_step (
    input  pxb_pkg::req_type_t req_type,
    input  pxb_pkg::level_t    level,
    input  pxb_pkg::value_t    val,
    input  pxb_pkg::position_t pos,
    input  pxb_pkg::position_t bound,
    input  pxb_pkg::value_t    acc,
    input  pxb_pkg::entry_t    slot,
    output pxb_pkg::step_out_t result
);

    always_comb
    begin
        result          = '0;
        result.val_next = val;
        result.pos_next = pos;
        result.acc_next = acc;
        result.wr_entry = slot;

        case (req_type)
            pxb_pkg::REQ_INSERT:
            begin
                if (val[level])
                begin
                    // carried value always ends up xored with the old vector
                    result.val_next = val ^ slot.vec;
                    // newer position takes the slot, older one moves down
                    if (pos > slot.pos)
                    begin
                        result.wr_en        = 1'b1;
                        result.wr_entry.vec = val;
                        result.wr_entry.pos = pos;
                        result.pos_next     = slot.pos;
                    end
                end
            end
            default:
            begin
                // greedy: take the slot if it raises this bit and qualifies
                if (!acc[level] && (slot.pos >= bound))
                begin
                    result.acc_next = acc ^ slot.vec;
                end
            end
        endcase
    end

endmodule

// ----- hdl/prefix_xor_basis_max_query.sv -----
// ----------------------------------------------------------------------------
// prefix_xor_basis_max_query
// Prefix linear basis over GF(2) with maximum-XOR queries on recent slots.
// ----------------------------------------------------------------------------
// Every beat, insert or query, is accepted in ST_IDLE, which issues the first
// read, then walks the bit levels one at a time from the top down in ST_RUN,
// because the carried value changes at each level and each level does a
// read-modify-write of its slot in the single basis memory (registered read,
// next level's read overlapped with this level's write). One beat is worked
// at a time; a query result sits in an output register, so the next beat is
// taken while it waits, and only a second query result waits for it to
// drain. Slots read as empty after reset through per-level valid flops, so
// there is no clearing pass and the block is ready right after reset.
module prefix_xor_basis_max_query (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic [pxb_pkg::VALUE_BITS-1:0]    value,
    input  logic [pxb_pkg::POSITION_BITS-1:0] position,
    input  logic [pxb_pkg::POSITION_BITS-1:0] from_position,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [pxb_pkg::VALUE_BITS-1:0]    max_xor
);

    pxb_pkg::state_t    state_reg, state_next;
    pxb_pkg::level_t    level_reg, level_next;
    pxb_pkg::req_type_t req_reg, req_next;
    pxb_pkg::value_t    val_reg, val_next;
    pxb_pkg::position_t pos_reg, pos_next;
    pxb_pkg::position_t bound_reg, bound_next;
    pxb_pkg::value_t    acc_reg, acc_next;
    logic [pxb_pkg::VALUE_BITS-1:0] slot_valid_reg, slot_valid_next;
    logic               out_valid_reg, out_valid_next;
    pxb_pkg::value_t    max_xor_reg, max_xor_next;

    logic               in_accept;
    logic               out_free;
    logic               mem_re;
    pxb_pkg::level_t    mem_raddr;
    pxb_pkg::entry_t    mem_rdata;
    pxb_pkg::entry_t    slot;
    pxb_pkg::step_out_t step;
    logic               mem_we;

    assign in_stall  = (state_reg != pxb_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign max_xor   = max_xor_reg;

    // Basis memory: one entry per bit level
    pxb_ram #(
        .WIDTH (pxb_pkg::ENTRY_BITS),
        .DEPTH (pxb_pkg::VALUE_BITS)
    ) u_basis_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (level_reg),
        .wdata (step.wr_entry),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Never-written slots read as empty
    assign slot = slot_valid_reg[level_reg] ? mem_rdata : '0;

    // Per-level update
    pxb_step u_step (
        .req_type (req_reg),
        .level    (level_reg),
        .val      (val_reg),
        .pos      (pos_reg),
        .bound    (bound_reg),
        .acc      (acc_reg),
        .slot     (slot),
        .result   (step)
    );

    assign mem_we = (state_reg == pxb_pkg::ST_RUN) && step.wr_en;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pxb_pkg::ST_IDLE;
            level_reg      <= pxb_pkg::TOP_LEVEL;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Beat payload and result registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        bound_reg   <= bound_next;
        acc_reg     <= acc_next;
        max_xor_reg <= max_xor_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        req_next        = req_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        bound_next      = bound_reg;
        acc_next        = acc_reg;
        slot_valid_next = slot_valid_reg;
        max_xor_next    = max_xor_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_re          = 1'b0;
        mem_raddr       = pxb_pkg::TOP_LEVEL;

        unique case (state_reg)
            pxb_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_next   = pxb_pkg::req_type_t'(req_type);
                    val_next   = value;
                    pos_next   = position;
                    bound_next = from_position;
                    acc_next   = '0;
                    level_next = pxb_pkg::TOP_LEVEL;
                    mem_re     = 1'b1;
                    state_next = pxb_pkg::ST_RUN;
                end
            end
            pxb_pkg::ST_RUN:
            begin
                val_next = step.val_next;
                pos_next = step.pos_next;
                acc_next = step.acc_next;
                if (mem_we)
                begin
                    slot_valid_next[level_reg] = 1'b1;
                end
                if (level_reg == pxb_pkg::BOTTOM_LEVEL)
                begin
                    if (req_reg == pxb_pkg::REQ_INSERT)
                    begin
                        state_next = pxb_pkg::ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        max_xor_next   = step.acc_next;
                        out_valid_next = 1'b1;
                        state_next     = pxb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = pxb_pkg::ST_HOLD;
                    end
                end
                else
                begin
                    // fetch the next level while this one writes back
                    level_next = level_reg - 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = level_reg - 1'b1;
                end
            end
            pxb_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    max_xor_next   = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = pxb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pxb_pkg::ST_IDLE;
            end
        endcase
    end

    // A result only appears at the end of a query
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(req_reg == pxb_pkg::REQ_QUERY)
            && ($past(state_reg == pxb_pkg::ST_RUN)
                || $past(state_reg == pxb_pkg::ST_HOLD)))
        else $error("result beat without a finished query");

    // Writes only during the level walk, never beyond the top slot
    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == pxb_pkg::ST_RUN)
            && (level_reg <= pxb_pkg::TOP_LEVEL))
        else $error("basis write outside the level walk");

    // An accepted beat starts its walk at the top level
    a_walk_starts_top: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == pxb_pkg::ST_RUN)
            && (level_reg == pxb_pkg::TOP_LEVEL))
        else $error("walk did not start at the top level");

    // The walk moves down one level per cycle
    a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pxb_pkg::ST_RUN) && (level_reg != pxb_pkg::BOTTOM_LEVEL)
            |=> (state_reg == pxb_pkg::ST_RUN)
                && (level_reg == $past(level_reg) - 1'b1))
        else $error("level walk skipped or stalled");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prefix_xor_basis_max_query.
// An initial block fills a backlog of insert and query beats: a short directed
// opening, then long runs of rising-position inserts mixed with window
// queries. A negedge driver feeds them through the valid/stall handshake with
// random gaps. A posedge watcher keeps its own copy of the basis, predicts each
// query's maximum XOR and checks results in order. The result side stalls at
// random.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_REQS  = 1150;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int RECENT_DEPTH = 32;

    typedef struct {
        pxb_pkg::req_type_t kind;
        pxb_pkg::value_t    value;
        pxb_pkg::position_t pos;
        pxb_pkg::position_t bound;
    } basis_req_t;

    // DUT ports
    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic               req_type      = 1'b0;
    pxb_pkg::value_t    value         = '0;
    pxb_pkg::position_t position      = '0;
    pxb_pkg::position_t from_position = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    pxb_pkg::value_t    max_xor;

    // Predicted basis contents, empty after reset
    pxb_pkg::value_t    slot_vec [pxb_pkg::VALUE_BITS] = '{default: '0};
    pxb_pkg::position_t slot_pos [pxb_pkg::VALUE_BITS] = '{default: '0};

    basis_req_t      req_backlog [$];
    pxb_pkg::value_t pending_max_xor [$];

    int reqs_total   = 0;
    int inserts_seen = 0;
    int queries_seen = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int cycle_count  = 0;

    // Handshake events seen at the last rising edge
    bit req_taken = 1'b0;
    bit res_taken = 1'b0;

    // Idle pacing per side
    bit in_calm      = 1'b0;
    bit out_calm     = 1'b0;
    int req_gap      = 0;
    int res_wait     = 0;
    bit res_wait_set = 1'b0;

    prefix_xor_basis_max_query u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .value         (value),
        .position      (position),
        .from_position (from_position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .max_xor       (max_xor)
    );

    always #4 clk = ~clk;

    // Reduce a value into the basis top-down; a newer position takes the slot
    // and the older vector, reduced, carries on with its own position.
    function automatic void basis_absorb(pxb_pkg::value_t v, pxb_pkg::position_t p);
        pxb_pkg::value_t    carried_v;
        pxb_pkg::position_t carried_p;
        pxb_pkg::value_t    old_v;
        pxb_pkg::position_t old_p;
        carried_v = v;
        carried_p = p;
        for (int lvl = pxb_pkg::VALUE_BITS - 1; lvl >= 0; lvl--)
        begin
            if (carried_v[lvl])
            begin
                if (carried_p > slot_pos[lvl])
                begin
                    old_v = slot_vec[lvl];
                    old_p = slot_pos[lvl];
                    slot_vec[lvl] = carried_v;
                    slot_pos[lvl] = carried_p;
                    carried_v = old_v ^ carried_v;
                    carried_p = old_p;
                end
                else
                begin
                    carried_v = carried_v ^ slot_vec[lvl];
                end
            end
        end
    endfunction

    // Greedy maximum over slots at or after the bound
    function automatic pxb_pkg::value_t best_xor_from(pxb_pkg::position_t bound);
        pxb_pkg::value_t acc;
        acc = '0;
        for (int lvl = pxb_pkg::VALUE_BITS - 1; lvl >= 0; lvl--)
        begin
            if (!acc[lvl] && slot_pos[lvl] >= bound)
                acc = acc ^ slot_vec[lvl];
        end
        return acc;
    endfunction

    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic void add_req(pxb_pkg::req_type_t kind, pxb_pkg::value_t v,
                                    pxb_pkg::position_t p, pxb_pkg::position_t b);
        basis_req_t r;
        r.kind  = kind;
        r.value = v;
        r.pos   = p;
        r.bound = b;
        req_backlog.push_back(r);
    endfunction

    // Request driver: hold a beat until taken, then wait its gap
    always @(negedge clk)
    begin : drive_req
        basis_req_t nxt;
        logic       raise;
        if (rst_n)
        begin
            raise = in_valid && !req_taken;
            if (!raise)
            begin
                if (req_gap > 0)
                    req_gap--;
                else if (req_backlog.size() > 0)
                begin
                    nxt = req_backlog.pop_front();
                    req_type      <= nxt.kind;
                    value         <= nxt.value;
                    position      <= nxt.pos;
                    from_position <= nxt.bound;
                    raise = 1'b1;
                    if ($urandom_range(0, 23) == 0)
                        in_calm = !in_calm;
                    req_gap = draw_wait(in_calm);
                end
            end
            in_valid <= raise;
        end
    end

    // Result stall: draw a wait for each result as it shows up
    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (res_taken)
                res_wait_set = 1'b0;
            if (out_valid && !res_wait_set)
            begin
                if ($urandom_range(0, 23) == 0)
                    out_calm = !out_calm;
                res_wait = draw_wait(out_calm);
                res_wait_set = 1'b1;
            end
            if (out_valid)
            begin
                if (res_wait > 0)
                begin
                    out_stall <= 1'b1;
                    res_wait--;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
            else
            begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watcher: check results against the oldest prediction, then update the
    // predicted basis with any accepted request beat.
    always @(posedge clk)
    begin : watch
        pxb_pkg::value_t want;
        if (rst_n)
        begin
            cycle_count++;
            req_taken = in_valid && !in_stall;
            res_taken = out_valid && !out_stall;

            if (res_taken)
            begin
                results_seen++;
                if (pending_max_xor.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] result with none expected: max_xor=%06h",
                                 $time, max_xor);
                end
                else
                begin
                    want = pending_max_xor.pop_front();
                    if (max_xor !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] max_xor mismatch: expected %06h got %06h",
                                     $time, want, max_xor);
                    end
                end
            end

            if (req_taken)
            begin
                if (req_type == pxb_pkg::REQ_INSERT)
                begin
                    basis_absorb(value, position);
                    inserts_seen++;
                end
                else
                begin
                    pending_max_xor.push_back(best_xor_from(from_position));
                    queries_seen++;
                end
            end

            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending_max_xor.size());
                $display("prefix_xor_basis_max_query verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        pxb_pkg::position_t cur_pos;
        pxb_pkg::position_t recent [RECENT_DEPTH];
        int                 n_recent;
        int                 room;
        int                 step_cap;
        int                 pick;
        pxb_pkg::value_t    v;
        pxb_pkg::position_t p;
        pxb_pkg::position_t b;

        // Directed opening: empty basis, field extremes, zero inserts,
        // position zero, stale and equal positions, bound extremes.
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h7FFFFF,  20'd1,     20'hFFFFF);
        add_req(pxb_pkg::REQ_INSERT, 23'h000000,  20'd2,     '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h000001,  20'd3,     '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h400000,  20'd4,     '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h2AAAAA,  20'd5,     '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h555555,  20'd6,     '0);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'd0);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'd5);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'd7);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'hFFFFF);
        add_req(pxb_pkg::REQ_INSERT, 23'h123456,  20'd0,     '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h0F0F0F,  20'd4,     '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h0F0F0F,  20'd6,     '0);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'd1);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'd6);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'd0);
        add_req(pxb_pkg::REQ_INSERT, 23'h000100,  20'd7,     '0);
        add_req(pxb_pkg::REQ_INSERT, 23'h7FFFFF,  20'd8,     20'hFFFFF);
        add_req(pxb_pkg::REQ_QUERY,  23'h7FFFFF,  20'hFFFFF, 20'd8);
        add_req(pxb_pkg::REQ_QUERY,  '0,          '0,        20'd7);

        // Random part: mostly rising positions spread over the whole range,
        // with queries whose bounds land on recent insert positions.
        cur_pos  = 20'd8;
        n_recent = 0;
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    b = '0;
                else if (pick < 14)
                    b = pxb_pkg::position_t'($urandom);
                else if (pick < 20 || n_recent == 0)
                    b = cur_pos + pxb_pkg::position_t'($urandom_range(0, 2));
                else
                    b = recent[$urandom_range(0, (n_recent < RECENT_DEPTH ?
                                                  n_recent : RECENT_DEPTH) - 1)]
                        + pxb_pkg::position_t'($urandom_range(0, 1));
                add_req(pxb_pkg::REQ_QUERY, pxb_pkg::value_t'($urandom),
                        pxb_pkg::position_t'($urandom), b);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    v = '0;
                else if (pick < 50)
                    v = pxb_pkg::value_t'($urandom);
                else if (pick < 80)
                    v = pxb_pkg::value_t'($urandom)
                        >> $urandom_range(0, pxb_pkg::VALUE_BITS - 1);
                else
                    v = (pxb_pkg::value_t'(1) << $urandom_range(0, pxb_pkg::VALUE_BITS - 1))
                        | (pxb_pkg::value_t'(1) << $urandom_range(0, pxb_pkg::VALUE_BITS - 1));

                pick = $urandom_range(0, 99);
                if (pick < 4)
                    p = '0;
                else if (pick < 10 || cur_pos == '1)
                    p = pxb_pkg::position_t'($urandom_range(1, cur_pos));
                else
                begin
                    room = (1 << pxb_pkg::POSITION_BITS) - 1 - int'(cur_pos);
                    step_cap = (3 * room) / (RANDOM_REQS - i + 1);
                    if (step_cap < 1)
                        step_cap = 1;
                    if (step_cap > room)
                        step_cap = room;
                    cur_pos = cur_pos + pxb_pkg::position_t'($urandom_range(1, step_cap));
                    p = cur_pos;
                    recent[n_recent % RECENT_DEPTH] = cur_pos;
                    n_recent++;
                end
                add_req(pxb_pkg::REQ_INSERT, v, p, pxb_pkg::position_t'($urandom));
            end
        end
        reqs_total = req_backlog.size();

        // Hold reset, then release it at a falling edge, away from the rising edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (inserts_seen + queries_seen < reqs_total)
            @(negedge clk);
        while (pending_max_xor.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        fail_count += pending_max_xor.size();

        $display("%0d beats in (%0d inserts, %0d queries), %0d results checked",
                 reqs_total, inserts_seen, queries_seen, results_seen);
        $display("%0d failures over %0d cycles", fail_count, cycle_count);
        if (fail_count == 0)
            $display("prefix_xor_basis_max_query verification clean");
        else
            $display("prefix_xor_basis_max_query verification failed");
        $finish;
    end

endmodule
